// ===== hw/rtl/tpcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpcb_pkg
// Shared types and constants of the touch point capture buffer: command
// codes, status codes, the decoded command and the result record.
// ---------------------------------------------------------------------------
package tpcb_pkg;

  // default store geometry
  localparam int unsigned STORE_DEPTH_DEF  = 512;
  localparam int unsigned CHUNK_POINTS_DEF = 25;

  // depth of the command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;

  // input opcodes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_FETCH = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_FILL  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_STARTED = 2'd1;
  localparam logic [1:0] ST_INVALID     = 2'd2;

  // decoded command kinds
  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_START = 3'd1,
    CMD_FETCH = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_FILL  = 3'd4,
    CMD_BAD   = 3'd5
  } cmd_kind_t;

  // one decoded transaction as it travels through the queue
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] time_ms;
    logic        mode;
    logic        rewind;
  } cmd_t;

  // one result record
  typedef struct packed {
    logic [1:0]  status;
    logic        has_point;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] time_ms;
    logic [4:0]  points_in_reply;
    logic [9:0]  total_frozen;
    logic [9:0]  points_left;
    logic        full_flag;
    logic [31:0] dropped_total;
    logic        collecting;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tpcb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpcb_front
// Input stage: accepts a transaction, classifies the opcode and holds the
// decoded command until the queue takes it.
// ---------------------------------------------------------------------------
module tpcb_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   in_opcode,
  input  wire logic [15:0]  in_point_x,
  input  wire logic [15:0]  in_point_y,
  input  wire logic [31:0]  in_time_ms,
  input  wire logic         in_start_mode,
  input  wire logic         in_rewind,
  output logic              cmd_valid,
  input  wire logic         cmd_ready,
  output tpcb_pkg::cmd_t    cmd
);
  import tpcb_pkg::*;

  logic      vld_r, vld_nxt;
  cmd_t      cmd_r;
  cmd_kind_t kind;
  logic      take;

  // opcode classification
  always_comb begin
    case (in_opcode)
      OP_ADD:   kind = CMD_ADD;
      OP_START: kind = CMD_START;
      OP_FETCH: kind = CMD_FETCH;
      OP_STOP:  kind = CMD_STOP;
      OP_FILL:  kind = CMD_FILL;
      default:  kind = CMD_BAD;
    endcase
  end

  // stage holds one command, frees when the queue takes it
  assign in_ready = !vld_r || cmd_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (cmd_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r.kind    <= kind;
      cmd_r.x       <= in_point_x;
      cmd_r.y       <= in_point_y;
      cmd_r.time_ms <= in_time_ms;
      cmd_r.mode    <= in_start_mode;
      cmd_r.rewind  <= in_rewind;
    end
  end

  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tpcb_cmdq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpcb_cmdq
// Short command queue between the front stage and the execution back end.
// ---------------------------------------------------------------------------
module tpcb_cmdq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire tpcb_pkg::cmd_t  push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output tpcb_pkg::cmd_t       pop_cmd
);
  import tpcb_pkg::*;

  localparam int unsigned PW = $clog2(CMDQ_DEPTH);
  localparam int unsigned NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          q_r [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = cnt_r != NW'(CMDQ_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = q_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tpcb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpcb_back
// Execution back end: capture state, point memory, fetch and fill
// sequencer, and the result output register.
// ---------------------------------------------------------------------------
module tpcb_back #(
  parameter int unsigned STORE_DEPTH  = tpcb_pkg::STORE_DEPTH_DEF,
  parameter int unsigned CHUNK_POINTS = tpcb_pkg::CHUNK_POINTS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire tpcb_pkg::cmd_t  cmd,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output tpcb_pkg::res_t       res
);
  import tpcb_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned KW = $clog2(CHUNK_POINTS + 1);

  typedef enum logic [5:0] {
    BK_IDLE  = 6'b000001,
    BK_PREP  = 6'b000010,
    BK_RD    = 6'b000100,
    BK_EMIT  = 6'b001000,
    BK_FILL  = 6'b010000,
    BK_REPLY = 6'b100000
  } bk_state_t;

  bk_state_t     state_r, state_nxt;
  logic [AW-1:0] write_pos_r, write_pos_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [31:0]   dropped_r, dropped_nxt;
  logic          stop_mode_r, stop_mode_nxt;
  logic          collect_r, collect_nxt;
  logic          full_r, full_nxt;
  logic          frozen_r, frozen_nxt;
  logic [CW-1:0] ft_r, ft_nxt;
  logic [CW-1:0] rp_r, rp_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [AW-1:0] rd_pos_r, rd_pos_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0] to_send_r, to_send_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [AW-1:0] fill_idx_r, fill_idx_nxt;
  logic [31:0]   fill_time_r, fill_time_nxt;
  res_t          rep_r, rep_nxt;
  res_t          out_r, out_nxt;

  logic [63:0]   mem [STORE_DEPTH];
  logic [63:0]   rdata_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;

  logic          slot_free;
  logic          is_full;
  logic [CW-1:0] base_rp, base_ft;
  logic [CW-1:0] remaining;
  logic [KW-1:0] to_send;
  logic [CW:0]   pos_sum;
  logic [31:0]   fill_wide;

  assign slot_free = !out_valid_r || res_ready;
  assign cmd_ready = state_r == BK_IDLE;
  assign is_full   = held_r == CW'(STORE_DEPTH);
  assign fill_wide = 32'(fill_idx_r);

  // chunk size and read start for a fetch
  assign remaining = ft_r - rp_r;
  assign to_send   = (32'(remaining) < 32'(CHUNK_POINTS)) ? KW'(remaining)
                                                          : KW'(CHUNK_POINTS);
  assign pos_sum   = (CW + 1)'(oldest_r) + (CW + 1)'(rp_r);

  // command execution sequencer
  always_comb begin
    state_nxt     = state_r;
    write_pos_nxt = write_pos_r;
    oldest_nxt    = oldest_r;
    held_nxt      = held_r;
    dropped_nxt   = dropped_r;
    stop_mode_nxt = stop_mode_r;
    collect_nxt   = collect_r;
    full_nxt      = full_r;
    frozen_nxt    = frozen_r;
    ft_nxt        = ft_r;
    rp_nxt        = rp_r;
    out_valid_nxt = out_valid_r;
    rd_pos_nxt    = rd_pos_r;
    cnt_nxt       = cnt_r;
    to_send_nxt   = to_send_r;
    left_nxt      = left_r;
    fill_idx_nxt  = fill_idx_r;
    fill_time_nxt = fill_time_r;
    rep_nxt       = rep_r;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = write_pos_r;
    wdata         = {cmd.time_ms, cmd.y, cmd.x};
    base_rp       = '0;
    base_ft       = '0;

    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          rep_nxt      = '0;
          rep_nxt.last = 1'b1;
          case (cmd.kind)
            CMD_ADD: begin
              // add point, or drop it when not collecting or when full in stop mode
              if (collect_r && !frozen_r) begin
                if (is_full && stop_mode_r) begin
                  full_nxt = 1'b1;
                end else begin
                  we            = 1'b1;
                  write_pos_nxt = (write_pos_r == AW'(STORE_DEPTH - 1)) ? '0
                                  : write_pos_r + AW'(1);
                  if (is_full) begin
                    oldest_nxt = (oldest_r == AW'(STORE_DEPTH - 1)) ? '0
                                 : oldest_r + AW'(1);
                    if (dropped_r != '1) begin
                      dropped_nxt = dropped_r + 32'd1;
                    end
                  end else begin
                    held_nxt = held_r + CW'(1);
                  end
                end
              end
            end
            CMD_START: begin
              write_pos_nxt      = '0;
              oldest_nxt         = '0;
              held_nxt           = '0;
              dropped_nxt        = '0;
              full_nxt           = 1'b0;
              frozen_nxt         = 1'b0;
              ft_nxt             = '0;
              rp_nxt             = '0;
              stop_mode_nxt      = cmd.mode;
              collect_nxt        = 1'b1;
              rep_nxt.collecting = 1'b1;
              state_nxt          = BK_REPLY;
            end
            CMD_FETCH: begin
              if (!collect_r && !frozen_r) begin
                rep_nxt.status = ST_NOT_STARTED;
                state_nxt      = BK_REPLY;
              end else begin
                // freeze on the first fetch, then rewind and clamp
                base_ft = frozen_r ? ft_r : held_r;
                base_rp = (frozen_r && !cmd.rewind) ? rp_r : '0;
                if (base_rp > base_ft) begin
                  base_rp = base_ft;
                end
                collect_nxt = 1'b0;
                frozen_nxt  = 1'b1;
                ft_nxt      = base_ft;
                rp_nxt      = base_rp;
                state_nxt   = BK_PREP;
              end
            end
            CMD_STOP: begin
              if (!collect_r && !frozen_r) begin
                rep_nxt.status = ST_NOT_STARTED;
              end else begin
                rep_nxt.dropped_total = dropped_r;
                write_pos_nxt         = '0;
                oldest_nxt            = '0;
                held_nxt              = '0;
                dropped_nxt           = '0;
                collect_nxt           = 1'b0;
                full_nxt              = 1'b0;
                frozen_nxt            = 1'b0;
                ft_nxt                = '0;
                rp_nxt                = '0;
              end
              state_nxt = BK_REPLY;
            end
            CMD_FILL: begin
              write_pos_nxt = '0;
              oldest_nxt    = '0;
              dropped_nxt   = '0;
              full_nxt      = 1'b0;
              held_nxt      = CW'(STORE_DEPTH);
              collect_nxt   = 1'b0;
              frozen_nxt    = 1'b1;
              ft_nxt        = CW'(STORE_DEPTH);
              rp_nxt        = '0;
              fill_idx_nxt  = '0;
              fill_time_nxt = cmd.time_ms;
              state_nxt     = BK_FILL;
            end
            default: begin
              rep_nxt.status = ST_INVALID;
              state_nxt      = BK_REPLY;
            end
          endcase
        end
      end
      BK_PREP: begin
        // size the chunk and find the first memory position
        to_send_nxt = to_send;
        left_nxt    = remaining - CW'(to_send);
        rp_nxt      = rp_r + CW'(to_send);
        rd_pos_nxt  = (pos_sum >= (CW + 1)'(STORE_DEPTH))
                      ? AW'(pos_sum - (CW + 1)'(STORE_DEPTH)) : AW'(pos_sum);
        cnt_nxt     = '0;
        if (to_send == '0) begin
          rep_nxt                 = '0;
          rep_nxt.total_frozen    = 10'(ft_r);
          rep_nxt.points_left     = 10'(remaining);
          rep_nxt.full_flag       = full_r;
          rep_nxt.dropped_total   = dropped_r;
          rep_nxt.last            = 1'b1;
          state_nxt               = BK_REPLY;
        end else begin
          state_nxt = BK_RD;
        end
      end
      BK_RD: begin
        // memory read in flight
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_nxt                 = '0;
          out_nxt.has_point       = 1'b1;
          out_nxt.x               = rdata_r[15:0];
          out_nxt.y               = rdata_r[31:16];
          out_nxt.time_ms         = rdata_r[63:32];
          out_nxt.points_in_reply = 5'(to_send_r);
          out_nxt.total_frozen    = 10'(ft_r);
          out_nxt.points_left     = 10'(left_r);
          out_nxt.full_flag       = full_r;
          out_nxt.dropped_total   = dropped_r;
          out_nxt.last            = (cnt_r + KW'(1)) == to_send_r;
          out_valid_nxt           = 1'b1;
          cnt_nxt                 = cnt_r + KW'(1);
          rd_pos_nxt              = (rd_pos_r == AW'(STORE_DEPTH - 1)) ? '0
                                    : rd_pos_r + AW'(1);
          state_nxt               = out_nxt.last ? BK_IDLE : BK_RD;
        end
      end
      BK_FILL: begin
        // index pattern sweep, one entry a cycle
        we           = 1'b1;
        waddr        = fill_idx_r;
        wdata        = {fill_time_r, fill_wide[31:16], fill_wide[15:0]};
        fill_idx_nxt = fill_idx_r + AW'(1);
        if (fill_idx_r == AW'(STORE_DEPTH - 1)) begin
          rep_nxt              = '0;
          rep_nxt.total_frozen = 10'(STORE_DEPTH);
          rep_nxt.last         = 1'b1;
          state_nxt            = BK_REPLY;
        end
      end
      BK_REPLY: begin
        if (slot_free) begin
          out_nxt       = rep_r;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      write_pos_r <= '0;
      oldest_r    <= '0;
      held_r      <= '0;
      dropped_r   <= '0;
      stop_mode_r <= 1'b0;
      collect_r   <= 1'b0;
      full_r      <= 1'b0;
      frozen_r    <= 1'b0;
      ft_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      write_pos_r <= write_pos_nxt;
      oldest_r    <= oldest_nxt;
      held_r      <= held_nxt;
      dropped_r   <= dropped_nxt;
      stop_mode_r <= stop_mode_nxt;
      collect_r   <= collect_nxt;
      full_r      <= full_nxt;
      frozen_r    <= frozen_nxt;
      ft_r        <= ft_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    rd_pos_r    <= rd_pos_nxt;
    cnt_r       <= cnt_nxt;
    to_send_r   <= to_send_nxt;
    left_r      <= left_nxt;
    fill_idx_r  <= fill_idx_nxt;
    fill_time_r <= fill_time_nxt;
    rep_r       <= rep_nxt;
    out_r       <= out_nxt;
  end

  // point memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_pos_r];
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/touch_point_capture_buffer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// touch_point_capture_buffer_core
// Ring capture of timestamped touch points with frozen chunked readback.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | opcode, point x/y, time, mode, rewind
//  result   | out_valid / out_ready| status, point, fetch summary, last
//
//  back end: add ends in idle; start / stop / invalid go via reply; a
//  fetch via prepare, then read and emit per point (registered memory
//  read port), via prepare and reply with no point, via reply when not
//  started; fill writes each entry; front stage and queue are registered.
//  reset is synchronous and clears all control state; the memory needs no
//  clearing pass since unwritten entries are never read.
//  either side may stall: a four-entry queue decouples input from execution.
// ---------------------------------------------------------------------------
module touch_point_capture_buffer_core #(
  parameter int unsigned STORE_DEPTH  = tpcb_pkg::STORE_DEPTH_DEF,
  parameter int unsigned CHUNK_POINTS = tpcb_pkg::CHUNK_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [15:0] in_point_x,
  input  wire logic [15:0] in_point_y,
  input  wire logic [31:0] in_time_ms,
  input  wire logic        in_start_mode,
  input  wire logic        in_rewind,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_has_point,
  output logic [15:0]      out_x,
  output logic [15:0]      out_y,
  output logic [31:0]      out_time_ms,
  output logic [4:0]       out_points_in_reply,
  output logic [9:0]       out_total_frozen,
  output logic [9:0]       out_points_left,
  output logic             out_full_flag,
  output logic [31:0]      out_dropped_total,
  output logic             out_collecting,
  output logic             out_last
);
  import tpcb_pkg::*;

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;
  res_t res;

  // input stage
  tpcb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_time_ms    (in_time_ms),
    .in_start_mode (in_start_mode),
    .in_rewind     (in_rewind),
    .cmd_valid     (fr_valid),
    .cmd_ready     (fr_ready),
    .cmd           (fr_cmd)
  );

  // command queue
  tpcb_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_cmd    (bk_cmd)
  );

  // execution back end
  tpcb_back #(
    .STORE_DEPTH  (STORE_DEPTH),
    .CHUNK_POINTS (CHUNK_POINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  // result fields
  assign out_status          = res.status;
  assign out_has_point       = res.has_point;
  assign out_x               = res.x;
  assign out_y               = res.y;
  assign out_time_ms         = res.time_ms;
  assign out_points_in_reply = res.points_in_reply;
  assign out_total_frozen    = res.total_frozen;
  assign out_points_left     = res.points_left;
  assign out_full_flag       = res.full_flag;
  assign out_dropped_total   = res.dropped_total;
  assign out_collecting      = res.collecting;
  assign out_last            = res.last;

  // a point only rides on a successful fetch with a nonzero chunk
  a_point_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_point) |-> (out_status == ST_OK && out_points_in_reply != 5'd0))
    else $error("point result without successful fetch");

  // failed commands produce exactly one result
  a_fail_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_last && !out_has_point))
    else $error("failed command result not single");

  // start reply is a single result without a point
  a_start_reply : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_collecting) |-> (out_last && !out_has_point && out_status == ST_OK))
    else $error("malformed start reply");

  // reset empties the output register
  a_reset_out : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the touch point capture buffer core. A shadow copy
// of the ring store predicts every reply; replies are compared field by field
// in order; both handshake sides idle at random outside the stress fill.
// ---------------------------------------------------------------------------
module testbench;
  import tpcb_pkg::*;

  localparam int unsigned DEPTH        = STORE_DEPTH_DEF;
  localparam int unsigned CHUNK        = CHUNK_POINTS_DEF;
  localparam int unsigned DRAIN_FETCH  = DEPTH / CHUNK + 2;
  localparam int unsigned RANDOM_ITEMS = 330;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // unused opcode values
  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [15:0] in_point_x;
  logic [15:0] in_point_y;
  logic [31:0] in_time_ms;
  logic        in_start_mode;
  logic        in_rewind;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_has_point;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [31:0] out_time_ms;
  logic [4:0]  out_points_in_reply;
  logic [9:0]  out_total_frozen;
  logic [9:0]  out_points_left;
  logic        out_full_flag;
  logic [31:0] out_dropped_total;
  logic        out_collecting;
  logic        out_last;

  // shadow capture state
  logic [63:0] shadow_store [DEPTH];
  int unsigned shadow_wr;
  int unsigned shadow_oldest;
  int unsigned shadow_held;
  logic [31:0] shadow_dropped;
  logic        shadow_stop_mode;
  logic        shadow_collect;
  logic        shadow_full;
  logic        shadow_frozen;
  int unsigned shadow_frozen_total;
  int unsigned shadow_read_pos;

  // replies predicted but not yet seen
  res_t pending_replies [$];

  int unsigned error_count;
  int unsigned results_checked;
  int unsigned points_read;
  int unsigned acted_items;
  int unsigned cycle_count;
  logic        steady_stretch;

  touch_point_capture_buffer_core #(
    .STORE_DEPTH (DEPTH),
    .CHUNK_POINTS(CHUNK)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_time_ms         (in_time_ms),
    .in_start_mode      (in_start_mode),
    .in_rewind          (in_rewind),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_has_point      (out_has_point),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_time_ms        (out_time_ms),
    .out_points_in_reply(out_points_in_reply),
    .out_total_frozen   (out_total_frozen),
    .out_points_left    (out_points_left),
    .out_full_flag      (out_full_flag),
    .out_dropped_total  (out_dropped_total),
    .out_collecting     (out_collecting),
    .out_last           (out_last)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d replies pending", cycle_count,
             pending_replies.size());
    $display("FAIL");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR: %s", msg);
  endtask

  function automatic res_t make_reply(input logic [1:0] st, input logic has_pt,
                                      input logic [63:0] pt, input int unsigned n_pts,
                                      input int unsigned total, input int unsigned left,
                                      input logic full, input logic [31:0] dropped,
                                      input logic coll, input logic fin);
    res_t r;
    r.status          = st;
    r.has_point       = has_pt;
    r.x               = has_pt ? pt[15:0] : 16'd0;
    r.y               = has_pt ? pt[31:16] : 16'd0;
    r.time_ms         = has_pt ? pt[63:32] : 32'd0;
    r.points_in_reply = 5'(n_pts);
    r.total_frozen    = 10'(total);
    r.points_left     = 10'(left);
    r.full_flag       = full;
    r.dropped_total   = dropped;
    r.collecting      = coll;
    r.last            = fin;
    return r;
  endfunction

  function automatic void clear_capture();
    shadow_wr           = 0;
    shadow_oldest       = 0;
    shadow_held         = 0;
    shadow_dropped      = 32'd0;
    shadow_collect      = 1'b0;
    shadow_full         = 1'b0;
    shadow_frozen       = 1'b0;
    shadow_frozen_total = 0;
    shadow_read_pos     = 0;
  endfunction

  // update the shadow state for one accepted transaction and queue its replies
  task automatic apply_command(input logic [2:0] op, input logic [15:0] px,
                               input logic [15:0] py, input logic [31:0] tm,
                               input logic mode, input logic rew);
    int unsigned remaining;
    int unsigned n_send;
    int unsigned pos;
    logic [31:0] held_drop;
    acted_items++;
    case (op)
      OP_ADD: begin
        if (!shadow_collect || shadow_frozen) begin
          acted_items--;
        end else begin
          if (shadow_held >= DEPTH) begin
            if (shadow_stop_mode) begin
              shadow_full = 1'b1;
            end else begin
              shadow_oldest = (shadow_oldest + 1) % DEPTH;
              shadow_held--;
              if (shadow_dropped != 32'hFFFF_FFFF) shadow_dropped++;
            end
          end
          if (shadow_held < DEPTH) begin
            shadow_store[shadow_wr] = {tm, py, px};
            shadow_wr = (shadow_wr + 1) % DEPTH;
            shadow_held++;
          end
        end
      end
      OP_START: begin
        clear_capture();
        shadow_stop_mode = mode;
        shadow_collect   = 1'b1;
        pending_replies.push_back(make_reply(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1, 1));
      end
      OP_FETCH: begin
        if (!shadow_collect && !shadow_frozen) begin
          pending_replies.push_back(make_reply(ST_NOT_STARTED, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          // first fetch freezes the store
          if (!shadow_frozen) begin
            shadow_collect      = 1'b0;
            shadow_frozen       = 1'b1;
            shadow_frozen_total = shadow_held;
            shadow_read_pos     = 0;
          end
          if (rew) shadow_read_pos = 0;
          if (shadow_read_pos > shadow_frozen_total) shadow_read_pos = shadow_frozen_total;
          remaining = shadow_frozen_total - shadow_read_pos;
          n_send    = (remaining < CHUNK) ? remaining : CHUNK;
          pos       = (shadow_oldest + shadow_read_pos) % DEPTH;
          shadow_read_pos += n_send;
          if (n_send == 0) begin
            pending_replies.push_back(make_reply(ST_OK, 0, 0, 0, shadow_frozen_total,
                                                 shadow_frozen_total - shadow_read_pos,
                                                 shadow_full, shadow_dropped, 0, 1));
          end else begin
            for (int unsigned i = 0; i < n_send; i++) begin
              pending_replies.push_back(make_reply(ST_OK, 1, shadow_store[pos], n_send,
                                                   shadow_frozen_total,
                                                   shadow_frozen_total - shadow_read_pos,
                                                   shadow_full, shadow_dropped, 0,
                                                   (i + 1 == n_send)));
              pos = (pos + 1) % DEPTH;
            end
          end
        end
      end
      OP_STOP: begin
        if (!shadow_collect && !shadow_frozen) begin
          pending_replies.push_back(make_reply(ST_NOT_STARTED, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          held_drop = shadow_dropped;
          clear_capture();
          pending_replies.push_back(make_reply(ST_OK, 0, 0, 0, 0, 0, 0, held_drop, 0, 1));
        end
      end
      OP_FILL: begin
        // index pattern over the whole store, frozen full
        for (int unsigned i = 0; i < DEPTH; i++) begin
          shadow_store[i] = {tm, 16'(i >> 16), 16'(i)};
        end
        shadow_wr           = 0;
        shadow_oldest       = 0;
        shadow_dropped      = 32'd0;
        shadow_full         = 1'b0;
        shadow_held         = DEPTH;
        shadow_collect      = 1'b0;
        shadow_frozen       = 1'b1;
        shadow_frozen_total = DEPTH;
        shadow_read_pos     = 0;
        pending_replies.push_back(make_reply(ST_OK, 0, 0, 0, DEPTH, 0, 0, 0, 0, 1));
      end
      default: begin
        pending_replies.push_back(make_reply(ST_INVALID, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      end
    endcase
  endtask

  // drive one transaction, hold it until accepted, then predict
  task automatic send_cmd(input logic [2:0] op, input logic [15:0] px,
                          input logic [15:0] py, input logic [31:0] tm,
                          input logic mode, input logic rew);
    @(negedge clk);
    while (!steady_stretch && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_point_x    <= px;
    in_point_y    <= py;
    in_time_ms    <= tm;
    in_start_mode <= mode;
    in_rewind     <= rew;
    do @(posedge clk); while (!in_ready);
    apply_command(op, px, py, tm, mode, rew);
  endtask

  task automatic send_op(input logic [2:0] op, input logic mode, input logic rew);
    send_cmd(op, 16'($urandom), 16'($urandom), $urandom, mode, rew);
  endtask

  task automatic send_add_random();
    send_op(OP_ADD, 1'($urandom), 1'($urandom));
  endtask

  task automatic drain_frozen();
    repeat (DRAIN_FETCH) send_op(OP_FETCH, 1'($urandom), 1'b0);
  endtask

  // result side: random stalls, steady during the stretch
  always @(negedge clk) begin
    out_ready <= steady_stretch || ($urandom_range(0, 99) >= 15);
  end

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                           results_checked, name, got, want));
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing pending", results_checked));
      end else begin
        want = pending_replies.pop_front();
        check_field("status", out_status, want.status);
        check_field("has_point", out_has_point, want.has_point);
        check_field("x", out_x, want.x);
        check_field("y", out_y, want.y);
        check_field("time_ms", out_time_ms, want.time_ms);
        check_field("points_in_reply", out_points_in_reply, want.points_in_reply);
        check_field("total_frozen", out_total_frozen, want.total_frozen);
        check_field("points_left", out_points_left, want.points_left);
        check_field("full_flag", out_full_flag, want.full_flag);
        check_field("dropped_total", out_dropped_total, want.dropped_total);
        check_field("collecting", out_collecting, want.collecting);
        check_field("last", out_last, want.last);
        if (want.has_point) points_read++;
      end
      results_checked++;
    end
  end

  // commands before any start, invalid codes, a short session in each mode
  task automatic test_directed();
    send_op(OP_FETCH, 0, 0);
    send_op(OP_STOP, 0, 0);
    send_op(OP_RSVD_LO, 0, 0);
    send_op(OP_RSVD_MID, 1, 1);
    send_op(OP_RSVD_HI, 0, 1);
    send_add_random();
    send_op(OP_START, 1'b0, 0);
    send_cmd(OP_ADD, 16'h0000, 16'h0000, 32'h0000_0000, 0, 0);
    send_cmd(OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1);
    send_add_random();
    send_add_random();
    send_op(OP_FETCH, 0, 1'b1);
    send_add_random();
    send_op(OP_FETCH, 0, 1'b0);
    send_op(OP_FETCH, 0, 1'b1);
    send_op(OP_STOP, 0, 0);
    send_op(OP_STOP, 0, 0);
    send_op(OP_START, 1'b1, 0);
    repeat (3) send_add_random();
    send_op(OP_FETCH, 0, 1'b0);
    send_op(OP_START, 1'b0, 0);
    send_op(OP_FETCH, 0, 1'b0);
    send_op(OP_STOP, 0, 0);
  endtask

  // overfill the ring in wrap mode so the oldest points get overwritten
  task automatic test_wrap_overflow();
    send_op(OP_START, 1'b0, 0);
    repeat (DEPTH + 18) send_add_random();
    drain_frozen();
    send_op(OP_FETCH, 0, 1'b1);
    send_op(OP_STOP, 0, 0);
  endtask

  // overfill in stop-when-full mode so new points are discarded
  task automatic test_stop_when_full();
    send_op(OP_START, 1'b1, 0);
    repeat (DEPTH + 9) send_add_random();
    drain_frozen();
    send_op(OP_FETCH, 0, 1'b1);
    send_op(OP_FETCH, 0, 1'b0);
    send_op(OP_STOP, 0, 0);
  endtask

  // stress fill readback, no idling on either side here
  task automatic test_stress_fill();
    steady_stretch = 1'b1;
    send_cmd(OP_FILL, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF, 0, 0);
    drain_frozen();
    send_op(OP_FETCH, 0, 1'b1);
    send_op(OP_START, 1'b1, 0);
    send_add_random();
    send_add_random();
    send_cmd(OP_FILL, 16'($urandom), 16'($urandom), 32'h0000_0000, 1, 1);
    send_op(OP_FETCH, 0, 1'b0);
    send_op(OP_FETCH, 0, 1'b0);
    send_op(OP_STOP, 0, 0);
    send_op(OP_FETCH, 0, 0);
    steady_stretch = 1'b0;
  endtask

  // mostly well-formed sessions with random content, some noise
  task automatic test_random_sessions();
    int unsigned target;
    int unsigned n_adds;
    target = acted_items + RANDOM_ITEMS;
    while (acted_items < target) begin
      if ($urandom_range(0, 99) < 12) begin
        send_op(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom));
      end else begin
        send_op(OP_START, 1'($urandom), 1'($urandom));
        n_adds = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
        repeat (n_adds) begin
          send_add_random();
          if ($urandom_range(0, 99) < 4) begin
            send_op(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), 0, 0);
          end
        end
        repeat ($urandom_range(1, 4)) begin
          send_op(OP_FETCH, 1'($urandom), ($urandom_range(0, 99) < 25));
          if ($urandom_range(0, 99) < 15) send_add_random();
        end
        if ($urandom_range(0, 99) < 6) begin
          send_op(OP_FILL, 1'($urandom), 1'($urandom));
          repeat ($urandom_range(1, 3)) send_op(OP_FETCH, 0, ($urandom_range(0, 99) < 20));
        end
        if ($urandom_range(0, 99) < 70) send_op(OP_STOP, 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_ADD;
    in_point_x     = 16'd0;
    in_point_y     = 16'd0;
    in_time_ms     = 32'd0;
    in_start_mode  = 1'b0;
    in_rewind      = 1'b0;
    out_ready      = 1'b1;
    steady_stretch = 1'b0;
    error_count     = 0;
    results_checked = 0;
    points_read     = 0;
    acted_items     = 0;
    for (int unsigned i = 0; i < DEPTH; i++) shadow_store[i] = 64'd0;
    clear_capture();
    shadow_stop_mode = 1'b0;

    // synchronous reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_wrap_overflow();
    test_stop_when_full();
    test_stress_fill();
    test_random_sessions();

    @(negedge clk);
    in_valid <= 1'b0;

    // let every pending reply come out, then a short quiet period
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d transactions in (wrap, stop-when-full, stress fill, noise),",
             acted_items);
    $display("%0d results checked, %0d stored points read back, %0d errors",
             results_checked, points_read, error_count);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tpcb_pkg.sv
hw/rtl/tpcb_front.sv
hw/rtl/tpcb_cmdq.sv
hw/rtl/tpcb_back.sv
hw/rtl/touch_point_capture_buffer_core.sv
dv/testbench.sv
